[hw/rtl/tfc_pkg.sv]
// tfc_pkg: shared types and constants of the triangle frustum clipper.
// No dependencies.
package tfc_pkg;

  localparam int unsigned RegCount = 6;
  localparam int unsigned MaxVerts = 9;
  // one stored vertex: x,y,z,u,v (16b each), r,g,b,a (8b each)
  localparam int unsigned VertW = 112;

  typedef logic [VertW-1:0] vert_t;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_RDA   = 12'b000000000010,
    ST_RDB   = 12'b000000000100,
    ST_DIST  = 12'b000000001000,
    ST_SUM   = 12'b000000010000,
    ST_DECIDE= 12'b000000100000,
    ST_DIV   = 12'b000001000000,
    ST_MUL   = 12'b000010000000,
    ST_WRX   = 12'b000100000000,
    ST_NEXT  = 12'b001000000000,
    ST_ORD   = 12'b010000000000,
    ST_OUT   = 12'b100000000000
  } state_e;

  function automatic logic signed [15:0] vx(vert_t v, int unsigned k);
    return v[16*k +: 16];
  endfunction

endpackage

[hw/rtl/tfc_ram.sv]
// tfc_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
module tfc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

[hw/rtl/tfc_div.sv]
// tfc_div: restoring divider, q = floor(n0*2^16/(n0+n1)), one bit per cycle.
// Depends on nothing.
module tfc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [49:0] num_i,
  input  logic [50:0] den_i,
  output logic        done_o,
  output logic [16:0] quot_o
);
  // numerator <= denominator, so quotient <= 2^16 fits 17 bits
  logic [50:0] rem_q, rem_d, den_q;
  logic [15:0] quot_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic [51:0] sh;
  logic        bit_ok;
  logic        first_ok;

  always_comb begin
    sh = {rem_q, 1'b0};
    bit_ok = (sh >= {1'b0, den_q});
    if (bit_ok) rem_d = 51'(sh - {1'b0, den_q});
    else        rem_d = sh[50:0];
  end

  // quotient bit 16 is the unshifted compare, taken at load
  assign first_ok = ({1'b0, num_i} >= den_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'd16;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 5'd1;
      if (cnt_q == 5'd1) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= first_ok ? 51'({1'b0, num_i} - den_i) : {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= {15'd0, first_ok};
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[14:0], bit_ok};
    end
  end

  // 16 shift steps after load; the last bit is taken combinationally
  assign done_o = busy_q && (cnt_q == 5'd1);
  assign quot_o = {quot_q, bit_ok};
endmodule

[hw/rtl/triangle_frustum_clipper_top.sv]
// triangle_frustum_clipper_top: Sutherland-Hodgman clipper of one triangle.
// Depends on tfc_pkg, tfc_ram, tfc_div.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------
//  vertex  | start / busy           | pos, tex, color (one vertex per word)
//  config  | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i (plane regs)
//  result  | out_valid_o (strobe)   | out_* , vertex_total_o, last_vertex_o
//
// The first two vertex words are only stored. The third runs the clip:
// per plane, per edge RDA, RDB, two DIST/SUM passes, DECIDE and NEXT, plus on
// a crossing edge DIV, MUL and WRX (16 divider steps, 9 lane multiplies, one
// write back); then ORD starts the read out and OUT gives one vertex per
// cycle. Reset clears control and the plane registers; the vertex RAM is
// undefined until written. Results cannot be stalled.
module triangle_frustum_clipper_top #(
  parameter int unsigned PlaneCount = 6,
  parameter int unsigned BankDepth  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic signed [15:0] pos_x_i, pos_y_i, pos_z_i, tex_u_i, tex_v_i,
  input  logic [7:0]  color_r_i, color_g_i, color_b_i, color_a_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output logic        out_valid_o,
  output logic signed [15:0] out_pos_x_o, out_pos_y_o, out_pos_z_o,
  output logic signed [15:0] out_tex_u_o, out_tex_v_o,
  output logic [7:0]  out_color_r_o, out_color_g_o, out_color_b_o, out_color_a_o,
  output logic [3:0]  vertex_total_o,
  output logic        last_vertex_o
);
  // bank select is the top address bit, so the RAM spans two full banks
  localparam int unsigned IW = $clog2(BankDepth);
  localparam int unsigned AW = IW + 1;

  tfc_pkg::state_e state_q, state_d;
  logic [63:0] plane_q [tfc_pkg::RegCount];
  logic [1:0]  idx_q;
  logic [2:0]  pl_q;        // current plane
  logic        src_q;       // source bank
  logic [3:0]  n_q, m_q, i_q;
  logic [3:0]  total_q;
  tfc_pkg::vert_t va_q, vb_q;
  logic signed [33:0] px_q, py_q, pz_q;
  logic signed [35:0] d0_q, d1_q;
  logic        pass_b_q;    // computing distance for B
  logic [16:0] t_q;
  logic [3:0]  k_q;         // interpolation lane
  tfc_pkg::vert_t vi_q;

  // memory port signals
  logic           we;
  logic [AW-1:0]  waddr, raddr;
  tfc_pkg::vert_t wdata, rdata;

  tfc_ram #(.Width(tfc_pkg::VertW), .Depth(2**AW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic        div_start, div_done;
  logic [49:0] div_num;
  logic [50:0] div_den;
  logic [16:0] div_q;
  tfc_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_q)
  );

  assign cfg_ready_o = 1'b1;
  assign busy = (state_q != tfc_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < int'(tfc_pkg::RegCount); r++) plane_q[r] <= '0;
    end else if (cfg_valid_i && (32'(cfg_index_i) < tfc_pkg::RegCount)) begin
      plane_q[cfg_index_i] <= cfg_data_i;
    end
  end

  logic [63:0] pl;
  assign pl = plane_q[pl_q];
  tfc_pkg::vert_t vcur;
  assign vcur = pass_b_q ? vb_q : va_q;

  logic [3:0] j_idx;
  assign j_idx = (i_q + 4'd1 == n_q) ? 4'd0 : i_q + 4'd1;
  logic in0, in1;
  assign in0 = !d0_q[35];
  assign in1 = !d1_q[35];
  logic [35:0] a0, a1;
  assign a0 = in0 ? d0_q : 36'(-d0_q);
  assign a1 = in1 ? d1_q : 36'(-d1_q);

  // one lane of the lerp: v0*2^16 + t*(v1-v0), floor >>16
  logic signed [16:0] lv0, lv1, ldiff;
  logic signed [35:0] lacc;
  logic [15:0] lres;
  always_comb begin
    if (k_q < 4'd5) begin
      lv0 = 17'(tfc_pkg::vx(va_q, 32'(k_q)));
      lv1 = 17'(tfc_pkg::vx(vb_q, 32'(k_q)));
    end else begin
      lv0 = {9'd0, va_q[80 + 8*(k_q-4'd5) +: 8]};
      lv1 = {9'd0, vb_q[80 + 8*(k_q-4'd5) +: 8]};
    end
    ldiff = lv1 - lv0;
    lacc = (36'(lv0) <<< 16) + $signed({1'b0, t_q}) * ldiff;
    lres = lacc[31:16];
  end

  logic [AW-1:0] a_addr, b_addr;
  assign a_addr = {src_q, i_q[IW-1:0]};
  assign b_addr = {src_q, j_idx[IW-1:0]};

  always_comb begin
    state_d = state_q;
    we = 1'b0;
    waddr = {~src_q, m_q[IW-1:0]};
    wdata = va_q;
    raddr = a_addr;
    div_start = 1'b0;
    div_num = 50'(a0);
    div_den = 51'({15'd0, a0} + {15'd0, a1});
    case (state_q)
      tfc_pkg::ST_IDLE: begin
        if (start) begin
          we = 1'b1;
          waddr = AW'(idx_q);
          wdata = {color_a_i, color_b_i, color_g_i, color_r_i,
                   tex_v_i, tex_u_i, pos_z_i, pos_y_i, pos_x_i};
          if (idx_q == 2'd2) state_d = tfc_pkg::ST_RDA;
        end
      end
      tfc_pkg::ST_RDA: begin raddr = a_addr; state_d = tfc_pkg::ST_RDB; end
      tfc_pkg::ST_RDB: begin raddr = b_addr; state_d = tfc_pkg::ST_DIST; end
      tfc_pkg::ST_DIST: state_d = tfc_pkg::ST_SUM;
      tfc_pkg::ST_SUM: state_d = pass_b_q ? tfc_pkg::ST_DECIDE : tfc_pkg::ST_DIST;
      tfc_pkg::ST_DECIDE: begin
        if (in0 && m_q < 4'(tfc_pkg::MaxVerts)) begin
          we = 1'b1;
          wdata = va_q;
        end
        if (in0 != in1 && (m_q + 4'(in0)) < 4'(tfc_pkg::MaxVerts)) begin
          div_start = 1'b1;
          state_d = tfc_pkg::ST_DIV;
        end else state_d = tfc_pkg::ST_NEXT;
      end
      tfc_pkg::ST_DIV: if (div_done) state_d = tfc_pkg::ST_MUL;
      tfc_pkg::ST_MUL: if (k_q == 4'd8) state_d = tfc_pkg::ST_WRX;
      tfc_pkg::ST_WRX: begin
        we = 1'b1;
        wdata = vi_q;
        state_d = tfc_pkg::ST_NEXT;
      end
      tfc_pkg::ST_NEXT: begin
        if (i_q + 4'd1 == n_q) begin
          if (m_q == 4'd0) state_d = tfc_pkg::ST_IDLE;
          else if (32'(pl_q) + 1 >= PlaneCount) begin
            state_d = tfc_pkg::ST_ORD;
          end else state_d = tfc_pkg::ST_RDA;
        end else state_d = tfc_pkg::ST_RDA;
      end
      tfc_pkg::ST_ORD: begin
        raddr = {src_q, i_q[IW-1:0]};
        state_d = tfc_pkg::ST_OUT;
      end
      tfc_pkg::ST_OUT: begin
        raddr = {src_q, IW'(i_q + 4'd1)};
        if (i_q + 4'd1 == n_q) state_d = tfc_pkg::ST_IDLE;
      end
      default: state_d = tfc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tfc_pkg::ST_IDLE;
      idx_q <= '0; pl_q <= '0; src_q <= 1'b0;
      n_q <= '0; m_q <= '0; i_q <= '0; pass_b_q <= 1'b0; k_q <= '0;
      total_q <= '0; out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_o <= (state_q == tfc_pkg::ST_OUT);
      case (state_q)
        tfc_pkg::ST_IDLE: if (start) begin
          idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
          pl_q <= '0; src_q <= 1'b0; n_q <= 4'd3; m_q <= '0; i_q <= '0;
        end
        tfc_pkg::ST_RDB: pass_b_q <= 1'b0;
        tfc_pkg::ST_SUM: pass_b_q <= ~pass_b_q;
        tfc_pkg::ST_DECIDE: begin
          k_q <= '0;
          if (in0 && m_q < 4'(tfc_pkg::MaxVerts)) m_q <= m_q + 4'd1;
        end
        tfc_pkg::ST_MUL: k_q <= k_q + 4'd1;
        tfc_pkg::ST_WRX: m_q <= m_q + 4'd1;
        tfc_pkg::ST_NEXT: begin
          if (i_q + 4'd1 == n_q) begin
            i_q <= '0; m_q <= '0; n_q <= m_q; src_q <= ~src_q;
            pl_q <= pl_q + 3'd1;
            total_q <= m_q;
          end else i_q <= i_q + 4'd1;
        end
        tfc_pkg::ST_OUT: i_q <= i_q + 4'd1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == tfc_pkg::ST_RDB) va_q <= rdata;
    if (state_q == tfc_pkg::ST_DIST && !pass_b_q) vb_q <= rdata;
    // first DIST pass takes A, the second takes B
    if (state_q == tfc_pkg::ST_DIST) begin
      px_q <= $signed(pl[15:0])  * $signed(vcur[15:0]);
      py_q <= $signed(pl[31:16]) * $signed(vcur[31:16]);
      pz_q <= $signed(pl[47:32]) * $signed(vcur[47:32]);
    end
    if (state_q == tfc_pkg::ST_SUM) begin
      if (pass_b_q) d1_q <= 36'(px_q) + 36'(py_q) + 36'(pz_q) + (36'($signed(pl[63:48])) <<< 14);
      else          d0_q <= 36'(px_q) + 36'(py_q) + 36'(pz_q) + (36'($signed(pl[63:48])) <<< 14);
    end
    if (div_done) t_q <= div_q;
    if (state_q == tfc_pkg::ST_MUL) begin
      if (k_q < 4'd5) vi_q[16*k_q +: 16] <= lres;
      else            vi_q[80 + 8*(k_q-4'd5) +: 8] <= lres[7:0];
    end
    if (state_q == tfc_pkg::ST_OUT) begin
      {out_color_a_o, out_color_b_o, out_color_g_o, out_color_r_o,
       out_tex_v_o, out_tex_u_o, out_pos_z_o, out_pos_y_o, out_pos_x_o} <= rdata;
      vertex_total_o <= total_q;
      last_vertex_o  <= (i_q + 4'd1 == n_q);
    end
  end
endmodule
